// File: sv/assert_macros.svh
// Assertion shorthands used by the checker file.
// The enclosing scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

// File: sv/trre_pkg.sv
package trre_pkg;

	// default sizes
	localparam int PIXEL_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 12;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_THRESHOLD = 3'd0;
	localparam cfg_index_t REG_X_FIRST   = 3'd1;
	localparam cfg_index_t REG_X_LAST    = 3'd2;
	localparam cfg_index_t REG_Y_FIRST   = 3'd3;
	localparam cfg_index_t REG_Y_LAST    = 3'd4;
	localparam cfg_index_t REG_Z_FIRST   = 3'd5;

	// register reset values
	localparam int THRESHOLD_RESET = 128;
	localparam int LAST_RESET      = 255;

endpackage

// File: sv/threshold_row_run_extractor.sv
// Threshold row-run extractor.
// Input channel: pixel_value with in_valid / in_stall, one pixel per
// transaction, raster order (x fastest, then row, then slice). A pixel at or
// above threshold is inside; each maximal inside run within a row yields one
// result transaction on the output channel (run_start_x, run_end_x inclusive,
// run_row, run_slice) with out_valid / out_stall.
// Configuration: cfg_we, cfg_index, cfg_data. Any write, including one to an
// unused index, restarts the scan: counters reload from x_first, y_first,
// z_first and an open run is dropped. Write only while idle.
// Throughput: one pixel per cycle while the output is not stalled. The closing
// pixel goes from the input register to the result register, which loads when
// the pixel is processed and offers the result until it is taken.
// Reset (arst_n low): registers take their defaults, the scan restarts, both
// pipeline stages empty.
// Output stall: the result register holds; the pixel in the input register
// waits behind it and in_stall rises only while both are full.
module threshold_row_run_extractor #(
	parameter int PIXEL_BITS = trre_pkg::PIXEL_BITS_DEF,
	parameter int COORD_BITS = trre_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel stream
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [PIXEL_BITS-1:0]        pixel_value,
	// run stream
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [COORD_BITS-1:0]               run_start_x,
	output logic [COORD_BITS-1:0]               run_end_x,
	output logic [COORD_BITS-1:0]               run_row,
	output logic [COORD_BITS-1:0]               run_slice,
	// configuration
	input  logic                                cfg_we,
	input  trre_pkg::cfg_index_t                cfg_index,
	input  logic [((PIXEL_BITS > COORD_BITS) ? PIXEL_BITS : COORD_BITS)-1:0] cfg_data
);

	typedef logic [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {COORD_BITS{1'b1}};

	// Configuration registers
	logic signed [PIXEL_BITS-1:0] threshold_q;
	coord_t x_first_q, x_last_q, y_first_q, y_last_q, z_first_q;

	// Values after a write in this cycle; restart loads from these
	logic signed [PIXEL_BITS-1:0] threshold_d;
	coord_t x_first_d, x_last_d, y_first_d, y_last_d, z_first_d;

	// Scan state
	coord_t col_q, row_q, slice_q, start_q;
	logic   open_q;

	// Input register
	logic                         valid_s1;
	logic signed [PIXEL_BITS-1:0] pixel_s1;

	// Result register
	logic   out_valid_q;
	coord_t start_x_q, end_x_q, row_res_q, slice_res_q;

	// Per-pixel decisions
	logic   can_proc, proc, in_acc;
	logic   pix_in, row_end;
	logic   open_mid;
	coord_t start_mid;
	logic   emit;
	coord_t emit_end;

	// Register write decode
	always_comb begin
		threshold_d = threshold_q;
		x_first_d   = x_first_q;
		x_last_d    = x_last_q;
		y_first_d   = y_first_q;
		y_last_d    = y_last_q;
		z_first_d   = z_first_q;
		if (cfg_we) begin
			unique case (cfg_index)
				trre_pkg::REG_THRESHOLD: threshold_d = cfg_data[PIXEL_BITS-1:0];
				trre_pkg::REG_X_FIRST:   x_first_d   = cfg_data[COORD_BITS-1:0];
				trre_pkg::REG_X_LAST:    x_last_d    = cfg_data[COORD_BITS-1:0];
				trre_pkg::REG_Y_FIRST:   y_first_d   = cfg_data[COORD_BITS-1:0];
				trre_pkg::REG_Y_LAST:    y_last_d    = cfg_data[COORD_BITS-1:0];
				trre_pkg::REG_Z_FIRST:   z_first_d   = cfg_data[COORD_BITS-1:0];
				default: ; // unused index: restart only
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= PIXEL_BITS'(trre_pkg::THRESHOLD_RESET);
			x_first_q   <= '0;
			x_last_q    <= COORD_BITS'(trre_pkg::LAST_RESET);
			y_first_q   <= '0;
			y_last_q    <= COORD_BITS'(trre_pkg::LAST_RESET);
			z_first_q   <= '0;
		end else begin
			threshold_q <= threshold_d;
			x_first_q   <= x_first_d;
			x_last_q    <= x_last_d;
			y_first_q   <= y_first_d;
			y_last_q    <= y_last_d;
			z_first_q   <= z_first_d;
		end
	end

	// Handshake: the input register moves on whenever the result register is
	// free or is being drained this cycle.
	assign can_proc = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && can_proc;
	assign in_stall = valid_s1 && !can_proc;
	assign in_acc   = in_valid && !in_stall;

	// Run detection on the pixel in the input register
	always_comb begin
		pix_in    = pixel_s1 >= threshold_q;
		row_end   = col_q == x_last_q;
		open_mid  = open_q;
		start_mid = start_q;
		emit      = 1'b0;
		emit_end  = col_q - coord_t'(1);
		if (pix_in) begin
			if (!open_q) begin
				open_mid  = 1'b1;
				start_mid = col_q;
			end
		end else if (open_q) begin
			// falling edge: run ended on the previous column
			emit     = 1'b1;
			open_mid = 1'b0;
		end
		if (row_end && open_mid) begin
			// row ends with the run still open
			emit     = 1'b1;
			emit_end = x_last_q;
			open_mid = 1'b0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel_value;
		end
	end

	// Scan counters and open run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
			open_q  <= 1'b0;
			start_q <= '0;
		end else if (cfg_we) begin
			col_q   <= x_first_d;
			row_q   <= y_first_d;
			slice_q <= z_first_d;
			open_q  <= 1'b0;
			start_q <= '0;
		end else if (proc) begin
			open_q  <= open_mid;
			start_q <= start_mid;
			if (row_end) begin
				col_q <= x_first_q;
				if (row_q == y_last_q) begin
					row_q <= y_first_q;
					if (slice_q != COORD_MAX) begin
						slice_q <= slice_q + coord_t'(1);
					end
				end else begin
					row_q <= row_q + coord_t'(1);
				end
			end else begin
				col_q <= col_q + coord_t'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			start_x_q   <= start_mid;
			end_x_q     <= emit_end;
			row_res_q   <= row_q;
			slice_res_q <= slice_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign run_start_x = start_x_q;
	assign run_end_x   = end_x_q;
	assign run_row     = row_res_q;
	assign run_slice   = slice_res_q;

endmodule

// File: sv/trre_checker.sv
`include "assert_macros.svh"

module trre_checker #(
	parameter int COORD_BITS = trre_pkg::COORD_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [COORD_BITS-1:0]               run_start_x,
	input logic [COORD_BITS-1:0]               run_end_x,
	input logic [COORD_BITS-1:0]               run_row,
	input logic [COORD_BITS-1:0]               run_slice
);

	logic in_acc;
	logic out_held;
	logic [4*COORD_BITS-1:0] out_pay;

	assign in_acc   = in_valid && !in_stall;
	assign out_held = out_valid && out_stall;
	assign out_pay  = {run_start_x, run_end_x, run_row, run_slice};

	// a stalled run transaction holds
	`ASSERT_NEXT(a_out_hold, out_held, out_valid)
	`ASSERT_NEXT(a_out_stable, out_held, $stable(out_pay))

	// input backs up only behind a held result
	`ASSERT_SAME(a_stall_cause, in_stall, out_held)

	// a fresh result comes from an accepted pixel that passed through the input register
	`ASSERT_SAME(a_result_src, $rose(out_valid), $past(in_acc, 2))

endmodule

bind threshold_row_run_extractor trre_checker #(
	.COORD_BITS(COORD_BITS)
) u_trre_checker (.*);

// File: tb/tb_threshold_row_run_extractor.sv
module tb_threshold_row_run_extractor;

	localparam int PB = trre_pkg::PIXEL_BITS_DEF;
	localparam int CB = trre_pkg::COORD_BITS_DEF;
	localparam int DW = (PB > CB) ? PB : CB;

	// indexes past the register list: the write only restarts the scan
	localparam trre_pkg::cfg_index_t REG_SPARE_LO = 3'd6;
	localparam trre_pkg::cfg_index_t REG_SPARE_HI = 3'd7;

	localparam int RANDOM_PIXELS = 1050;
	localparam int HOLD_PHASE    = 3;     // phase that gets the long output hold-off
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;     // two-stage pipe plus margin
	localparam int MAX_REPORTS   = 10;

	// how the expected run of a pixel is obtained
	typedef enum logic [1:0] {
		EXP_PREDICT,   // from the scan predictor
		EXP_NONE,      // typed: this pixel closes no run
		EXP_RUN        // typed: this pixel closes the run given
	} check_t;

	typedef struct packed {
		logic [CB-1:0] start_x;
		logic [CB-1:0] end_x;
		logic [CB-1:0] row;
		logic [CB-1:0] slc;
	} run_t;

	typedef struct packed {
		logic [PB-1:0] value;
		check_t        chk;
		run_t          typed;
	} pix_item_t;

	// one row of the directed table: a register write or a pixel
	typedef struct packed {
		bit                   is_cfg;
		trre_pkg::cfg_index_t idx;
		logic [DW-1:0]        data;
		check_t               chk;
		run_t                 typed;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [PB-1:0] pixel_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CB-1:0]        run_start_x;
	logic [CB-1:0]        run_end_x;
	logic [CB-1:0]        run_row;
	logic [CB-1:0]        run_slice;
	logic                 cfg_we = 1'b0;
	trre_pkg::cfg_index_t cfg_index = '0;
	logic [DW-1:0]        cfg_data = '0;

	threshold_row_run_extractor u_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .pixel_value,
		.out_valid, .out_stall, .run_start_x, .run_end_x, .run_row, .run_slice,
		.cfg_we, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Scan predictor: own copy of the registers and the raster state
	// ---------------------------------------------------------------
	logic signed [PB-1:0] thr_r     = PB'(trre_pkg::THRESHOLD_RESET);
	logic [CB-1:0]        x_first_r = '0;
	logic [CB-1:0]        x_last_r  = CB'(trre_pkg::LAST_RESET);
	logic [CB-1:0]        y_first_r = '0;
	logic [CB-1:0]        y_last_r  = CB'(trre_pkg::LAST_RESET);
	logic [CB-1:0]        z_first_r = '0;
	logic [CB-1:0]        col_cnt   = '0;
	logic [CB-1:0]        row_cnt   = '0;
	logic [CB-1:0]        slice_cnt = '0;
	bit                   run_open  = 1'b0;
	logic [CB-1:0]        open_start = '0;

	pix_item_t pixel_fifo [$];    // pixels waiting to be offered
	run_t      pending_runs [$];  // runs the block still owes
	int        bad_runs = 0;
	int        hold_req = 0;      // bumped by the stimulus to ask for a long hold-off

	// Advances the raster by one pixel; hit is set when a run closes.
	function automatic void scan_pixel(input logic signed [PB-1:0] v,
			output bit hit, output run_t r);
		bit pix_in;
		bit row_end;
		pix_in  = (v >= thr_r);
		row_end = (col_cnt == x_last_r);
		hit = 1'b0;
		r   = '0;
		if (pix_in) begin
			if (!run_open) begin
				run_open   = 1'b1;
				open_start = col_cnt;
			end
		end else if (run_open) begin
			// falling edge: the run ended on the previous column (wraps at 0)
			r = '{open_start, col_cnt - 1'b1, row_cnt, slice_cnt};
			run_open = 1'b0;
			hit = 1'b1;
		end
		if (row_end && run_open) begin
			r = '{open_start, x_last_r, row_cnt, slice_cnt};
			run_open = 1'b0;
			hit = 1'b1;
		end
		if (row_end) begin
			col_cnt = x_first_r;
			if (row_cnt == y_last_r) begin
				row_cnt = y_first_r;
				if (slice_cnt != '1)       // slice counter saturates
					slice_cnt++;
			end else begin
				row_cnt++;
			end
		end else begin
			col_cnt++;
		end
	endfunction

	function automatic void note_bad(input string msg);
		bad_runs++;
		if (bad_runs <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endfunction

	// ---------------------------------------------------------------
	// Pixel sender: bursts of random length, random gaps in between.
	// Predicts at the edge where the transaction is accepted.
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		bit   hit;
		run_t r;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			pixel_value <= '0;
			burst_left  = 0;
			gap_left    = 0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_pixel(pixel_value, hit, r);
				// typed rows override the predictor, which still tracks state
				case (pixel_fifo[0].chk)
					EXP_NONE: hit = 1'b0;
					EXP_RUN: begin
						hit = 1'b1;
						r   = pixel_fifo[0].typed;
					end
					default: ;
				endcase
				if (hit)
					pending_runs.push_back(r);
				void'(pixel_fifo.pop_front());
			end
			// a stalled transaction keeps valid and payload as they are
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_fifo.size() != 0) begin
					in_valid    <= 1'b1;
					pixel_value <= pixel_fifo[0].value;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(24, 1);
						// a quarter of the bursts run straight into the next one
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Run receiver and checker. Stall pattern changes per segment;
	// a long hold-off is served whenever hold_req moves.
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int seg_left   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	always @(posedge clk or negedge arst_n) begin
		run_t want;
		run_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{run_start_x, run_end_x, run_row, run_slice};
				if (pending_runs.size() == 0) begin
					note_bad($sformatf("unexpected run: start %0d end %0d row %0d slice %0d",
						got.start_x, got.end_x, got.row, got.slc));
				end else begin
					want = pending_runs.pop_front();
					if (got.start_x !== want.start_x || got.end_x !== want.end_x ||
							got.row !== want.row || got.slc !== want.slc)
						note_bad($sformatf({"run mismatch: expected %0d..%0d row %0d slice %0d,",
							" got %0d..%0d row %0d slice %0d"},
							want.start_x, want.end_x, want.row, want.slc,
							got.start_x, got.end_x, got.row, got.slc));
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					stall_mode = $urandom_range(3);
					seg_left   = $urandom_range(128, 16);
				end else begin
					seg_left--;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;                        // free flowing
					1: out_stall <= ($urandom_range(9) < 3);     // light back-pressure
					2: out_stall <= ($urandom_range(9) < 7);     // heavy back-pressure
					default: out_stall <= ~out_stall;            // alternating stall
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// Helpers for the stimulus
	// ---------------------------------------------------------------

	// Wait until no pixel is queued or offered and every run has come back;
	// then let the pipe empty.
	task automatic settle();
		do @(negedge clk);
		while (pixel_fifo.size() != 0 || in_valid || pending_runs.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register write; every write restarts the scan in the predictor too.
	task automatic write_reg(input trre_pkg::cfg_index_t idx, input logic [DW-1:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			trre_pkg::REG_THRESHOLD: thr_r     = d[PB-1:0];
			trre_pkg::REG_X_FIRST:   x_first_r = d[CB-1:0];
			trre_pkg::REG_X_LAST:    x_last_r  = d[CB-1:0];
			trre_pkg::REG_Y_FIRST:   y_first_r = d[CB-1:0];
			trre_pkg::REG_Y_LAST:    y_last_r  = d[CB-1:0];
			trre_pkg::REG_Z_FIRST:   z_first_r = d[CB-1:0];
			default: ;
		endcase
		col_cnt    = x_first_r;
		row_cnt    = y_first_r;
		slice_cnt  = z_first_r;
		run_open   = 1'b0;
		open_start = '0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic step_t cfg_row(input trre_pkg::cfg_index_t idx,
			input logic [DW-1:0] d);
		return '{1'b1, idx, d, EXP_PREDICT, '0};
	endfunction

	function automatic step_t pix_row(input logic signed [PB-1:0] v, input check_t chk,
			input int sx = 0, input int ex = 0, input int row = 0, input int slc = 0);
		run_t r;
		r = '{CB'(sx), CB'(ex), CB'(row), CB'(slc)};
		return '{1'b0, trre_pkg::REG_THRESHOLD, DW'(v), chk, r};
	endfunction

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		step_t         plan [$];
		int            sent;
		int            phase;
		int            n;
		int            k;
		int            t;
		int            v;
		bit            want_in;
		logic [DW-1:0] d;
		logic [CB-1:0] c;
		logic [CB-1:0] w;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		plan = '{
			// reset settings: threshold 128, columns 0..255
			pix_row(16'sd128, EXP_NONE),                      // equal to threshold: inside
			pix_row(16'sd127, EXP_RUN, 0, 0, 0, 0),           // falling edge, one-pixel run
			pix_row(16'sd32767, EXP_NONE),
			pix_row(-16'sd32768, EXP_RUN, 2, 2, 0, 0),
			// four columns across the wrap, one row per slice, near slice saturation;
			// upper data bits of the coordinate registers must be dropped
			cfg_row(trre_pkg::REG_THRESHOLD, 16'h7FFF),
			cfg_row(trre_pkg::REG_X_FIRST, 16'hFFFE),
			cfg_row(trre_pkg::REG_X_LAST, 16'hF001),
			cfg_row(trre_pkg::REG_Y_FIRST, 16'h0FFF),
			cfg_row(trre_pkg::REG_Y_LAST, 16'hFFFF),
			cfg_row(trre_pkg::REG_Z_FIRST, 16'h0FFE),
			pix_row(16'sd32767, EXP_NONE),
			pix_row(16'sd32767, EXP_NONE),
			pix_row(16'sd32766, EXP_RUN, 4094, 4095, 4095, 4094),  // end wraps back
			pix_row(16'sd32767, EXP_RUN, 1, 1, 4095, 4094),        // opens and closes at row end
			pix_row(16'sd0, EXP_PREDICT),
			pix_row(16'sd0, EXP_PREDICT),
			pix_row(16'sd32767, EXP_PREDICT),
			pix_row(16'sd32767, EXP_RUN, 0, 1, 4095, 4095),
			pix_row(16'sd32767, EXP_PREDICT),
			pix_row(16'sd32767, EXP_PREDICT),
			pix_row(16'sd32767, EXP_PREDICT),
			pix_row(16'sd32767, EXP_RUN, 4094, 1, 4095, 4095),     // slice stays saturated
			// lowest threshold: everything inside; open run dropped by a spare write
			cfg_row(trre_pkg::REG_THRESHOLD, 16'h8000),
			pix_row(-16'sd32768, EXP_NONE),
			pix_row(-16'sd32768, EXP_NONE),
			cfg_row(REG_SPARE_HI, 16'hFFFF),
			pix_row(16'sd5, EXP_PREDICT),
			pix_row(-16'sd1, EXP_PREDICT),
			pix_row(-16'sd32768, EXP_PREDICT),
			pix_row(16'sd32767, EXP_RUN, 4094, 1, 4095, 4094)
		};

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				@(negedge clk);
				pixel_fifo.push_back('{plan[i].data[PB-1:0], plan[i].chk, plan[i].typed});
			end
		end

		// Random phases: new settings while idle, then a run-structured pixel stream.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			settle();
			if ($urandom_range(2) != 0 || phase == HOLD_PHASE) begin
				case ($urandom_range(5))
					0: t = -32768;
					1: t = 32767;
					2: t = 0;
					3: t = -1;
					4: t = trre_pkg::THRESHOLD_RESET;
					default: t = $urandom_range(65535) - 32768;
				endcase
				if (phase == HOLD_PHASE)
					t = 0;     // plenty of runs while the output is held off
				d = t[DW-1:0];
				write_reg(trre_pkg::REG_THRESHOLD, d);
			end
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(3))
					0: c = '0;
					1: c = '1;
					2: c = 12'hFFF - CB'($urandom_range(7));   // rows that cross the wrap
					default: c = CB'($urandom);
				endcase
				w = ($urandom_range(3) == 0) ? '0 : CB'($urandom_range(15, 1));
				d = DW'($urandom);
				d[CB-1:0] = c;
				write_reg(trre_pkg::REG_X_FIRST, d);
				d = DW'($urandom);
				d[CB-1:0] = c + w;
				write_reg(trre_pkg::REG_X_LAST, d);
			end
			if ($urandom_range(2) != 0) begin
				c = ($urandom_range(2) == 0) ? '1 : CB'($urandom);
				w = CB'($urandom_range(3));
				d = DW'($urandom);
				d[CB-1:0] = c;
				write_reg(trre_pkg::REG_Y_FIRST, d);
				d = DW'($urandom);
				d[CB-1:0] = c + w;
				write_reg(trre_pkg::REG_Y_LAST, d);
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(3))
					0: c = '0;
					1: c = '1;
					2: c = 12'hFFE;
					default: c = CB'($urandom);
				endcase
				d = DW'($urandom);
				d[CB-1:0] = c;
				write_reg(trre_pkg::REG_Z_FIRST, d);
			end
			if ($urandom_range(3) == 0)
				write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, DW'($urandom));

			// Runs: the inside/outside state flips now and then; values land anywhere
			// on their side of the threshold, sometimes right at the edge, and a
			// fifth of the pixels are pure noise.
			n = $urandom_range(100, 40);
			t = thr_r;
			want_in = $urandom_range(1);
			@(negedge clk);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(3) == 0)
					want_in = !want_in;
				if ($urandom_range(4) == 0)
					v = $urandom_range(65535) - 32768;
				else if ($urandom_range(7) == 0)
					v = want_in ? t : t - 1;
				else if (want_in || t == -32768)
					v = t + $urandom_range(32767 - t);
				else
					v = -32768 + $urandom_range(t + 32767);
				pixel_fifo.push_back('{v[PB-1:0], EXP_PREDICT, '0});
			end
			// long hold-off while the sender keeps offering: fills the pipe
			if (phase == HOLD_PHASE)
				hold_req++;
			sent += n;
			phase++;
		end

		settle();
		if (bad_runs == 0) begin
			$display("tb_threshold_row_run_extractor: done, clean");
		end else begin
			$display("tb_threshold_row_run_extractor: done, errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb_threshold_row_run_extractor: done, errors");
		$finish;
	end

endmodule
